// ----- sv/assert_macros.svh -----
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ueq_pkg.sv -----
// package: shared types, constants and register map of the echo qualifier
`default_nettype none
package ueq_pkg;

  localparam int unsigned ECHO_TIMEOUT_US = 30000;
  localparam int unsigned DIST_SCALE = 17983;
  localparam int unsigned DIST_SHIFT = 12;
  localparam int unsigned DIST_MAX = 131071;

  localparam int unsigned ECHO_W = 15;
  localparam int unsigned DIST_CFG_W = 17;
  localparam int unsigned DIST_W = 18;
  localparam int unsigned PROD_W = 30;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned THR_W = 8;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic signed [DIST_W-1:0] NO_DISTANCE = -18'sd256;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TIMEOUT      = 3'd1,
    ST_TOO_SHORT    = 3'd2,
    ST_TOO_LONG     = 3'd3,
    ST_OUT_OF_RANGE = 3'd4,
    ST_INVALID      = 3'd5,
    ST_SENSOR_ERROR = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    REG_MIN_ECHO  = 3'd0,
    REG_MAX_ECHO  = 3'd1,
    REG_MIN_DIST  = 3'd2,
    REG_MAX_DIST  = 3'd3,
    REG_ABS_THR   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ECHO_W-1:0]     min_echo_time;
    logic [ECHO_W-1:0]     max_echo_time;
    logic [DIST_CFG_W-1:0] min_distance;
    logic [DIST_CFG_W-1:0] max_distance;
    logic [THR_W-1:0]      absence_threshold;
  } cfg_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DIST_W-1:0] distance;
    logic                     present;
    logic                     line_ok;
    logic [ECHO_W-1:0]        echo_time;
    logic                     timeout;
    logic [THR_W-1:0]         cons_next;
  } eval_t;

endpackage
`default_nettype wire

// ----- sv/ueq_cfg.sv -----
// configuration registers behind the apb-style port
`default_nettype none
module ueq_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ueq_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ueq_pkg::DATA_W-1:0]   pwdata,
  output logic      [ueq_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output ueq_pkg::cfg_t                     cfg
);

  ueq_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = ueq_pkg::reg_idx_t'(paddr[ueq_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_echo_time     <= ueq_pkg::ECHO_W'(115);
      cfg.max_echo_time     <= ueq_pkg::ECHO_W'(23500);
      cfg.min_distance      <= ueq_pkg::DIST_CFG_W'(512);
      cfg.max_distance      <= ueq_pkg::DIST_CFG_W'(102400);
      cfg.absence_threshold <= ueq_pkg::THR_W'(3);
    end else if (wr) begin
      unique case (idx)
        ueq_pkg::REG_MIN_ECHO: cfg.min_echo_time <= pwdata[ueq_pkg::ECHO_W-1:0];
        ueq_pkg::REG_MAX_ECHO: cfg.max_echo_time <= pwdata[ueq_pkg::ECHO_W-1:0];
        ueq_pkg::REG_MIN_DIST: cfg.min_distance  <= pwdata[ueq_pkg::DIST_CFG_W-1:0];
        ueq_pkg::REG_MAX_DIST: cfg.max_distance  <= pwdata[ueq_pkg::DIST_CFG_W-1:0];
        ueq_pkg::REG_ABS_THR:  cfg.absence_threshold <= pwdata[ueq_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      ueq_pkg::REG_MIN_ECHO: prdata = ueq_pkg::DATA_W'(cfg.min_echo_time);
      ueq_pkg::REG_MAX_ECHO: prdata = ueq_pkg::DATA_W'(cfg.max_echo_time);
      ueq_pkg::REG_MIN_DIST: prdata = ueq_pkg::DATA_W'(cfg.min_distance);
      ueq_pkg::REG_MAX_DIST: prdata = ueq_pkg::DATA_W'(cfg.max_distance);
      ueq_pkg::REG_ABS_THR:  prdata = ueq_pkg::DATA_W'(cfg.absence_threshold);
      default:               prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/ueq_eval.sv -----
// classification of one measurement: distance scaling, limit checks, timeout run
`default_nettype none
module ueq_eval (
  input  wire logic                         stuck,
  input  wire logic [ueq_pkg::ECHO_W-1:0]   duration,
  input  wire ueq_pkg::cfg_t                cfg,
  input  wire logic [ueq_pkg::THR_W-1:0]    cons,
  output ueq_pkg::eval_t                    ev
);

  logic [ueq_pkg::ECHO_W-1:0] dur;
  logic [ueq_pkg::PROD_W-1:0] prod;
  logic [ueq_pkg::DIST_W-1:0] scaled;
  logic [ueq_pkg::THR_W-1:0]  cons_inc;
  logic                       over_limit;

  assign over_limit = {1'b0, duration} > 16'(ueq_pkg::ECHO_TIMEOUT_US);
  assign dur        = over_limit ? '0 : duration;
  assign prod       = ueq_pkg::PROD_W'(dur) * ueq_pkg::PROD_W'(ueq_pkg::DIST_SCALE);
  assign scaled     = prod[ueq_pkg::PROD_W-1:ueq_pkg::DIST_SHIFT];
  assign cons_inc   = (cons == '1) ? cons : cons + 1'b1;

  always_comb begin
    ev.status    = ueq_pkg::ST_OK;
    ev.distance  = ueq_pkg::NO_DISTANCE;
    ev.present   = 1'b1;
    ev.line_ok   = 1'b1;
    ev.echo_time = dur;
    ev.timeout   = 1'b0;
    ev.cons_next = '0;
    priority if (stuck) begin
      ev.status    = ueq_pkg::ST_SENSOR_ERROR;
      ev.line_ok   = 1'b0;
      ev.present   = 1'b0;
      ev.echo_time = '0;
      ev.cons_next = cfg.absence_threshold;
    end else if (dur == '0) begin
      ev.status    = ueq_pkg::ST_TIMEOUT;
      ev.timeout   = 1'b1;
      ev.cons_next = cons_inc;
      ev.present   = cons_inc < cfg.absence_threshold;
    end else if (dur < cfg.min_echo_time) begin
      ev.status = ueq_pkg::ST_TOO_SHORT;
    end else if (dur > cfg.max_echo_time) begin
      ev.status = ueq_pkg::ST_TOO_LONG;
    end else begin
      if (scaled < {1'b0, cfg.min_distance} || scaled > {1'b0, cfg.max_distance}) begin
        ev.status = ueq_pkg::ST_OUT_OF_RANGE;
      end
      ev.distance = (scaled > ueq_pkg::DIST_W'(ueq_pkg::DIST_MAX))
                    ? ueq_pkg::DIST_W'(ueq_pkg::DIST_MAX) : scaled;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ueq_pipe.sv -----
// input register, running counters and result register around the evaluator
`default_nettype none
module ueq_pipe (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ueq_pkg::cfg_t                 cfg,
  input  wire logic                          meas_valid,
  output logic                               meas_stall,
  input  wire logic                          echo_stuck_high,
  input  wire logic [ueq_pkg::ECHO_W-1:0]    echo_duration,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic [2:0]                         status,
  output logic signed [ueq_pkg::DIST_W-1:0]  distance,
  output logic                               present,
  output logic                               echo_line_ok,
  output logic [ueq_pkg::ECHO_W-1:0]         echo_time,
  output logic [ueq_pkg::CNT_W-1:0]          reads_total,
  output logic [ueq_pkg::CNT_W-1:0]          timeouts_total
);

  logic                        in_full;
  logic                        in_stuck;
  logic [ueq_pkg::ECHO_W-1:0]  in_dur;
  logic [ueq_pkg::THR_W-1:0]   cons;
  logic [ueq_pkg::CNT_W-1:0]   read_cnt;
  logic [ueq_pkg::CNT_W-1:0]   timeout_cnt;
  logic [ueq_pkg::CNT_W-1:0]   read_cnt_next;
  logic [ueq_pkg::CNT_W-1:0]   timeout_cnt_next;
  logic                        advance;
  logic                        fire;
  logic                        take;
  ueq_pkg::eval_t              ev;

  assign advance    = !res_valid || !res_stall;
  assign fire       = in_full && advance;
  assign meas_stall = in_full && !advance;
  assign take       = meas_valid && !meas_stall;

  ueq_eval u_eval (
    .stuck    (in_stuck),
    .duration (in_dur),
    .cfg      (cfg),
    .cons     (cons),
    .ev       (ev)
  );

  assign read_cnt_next    = read_cnt + 1'b1;
  assign timeout_cnt_next = timeout_cnt + ueq_pkg::CNT_W'(ev.timeout);

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_stuck <= echo_stuck_high;
      in_dur   <= echo_duration;
    end
  end

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      cons        <= '0;
      read_cnt    <= '0;
      timeout_cnt <= '0;
    end else if (fire) begin
      cons        <= ev.cons_next;
      read_cnt    <= read_cnt_next;
      timeout_cnt <= timeout_cnt_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status         <= ev.status;
      distance       <= ev.distance;
      present        <= ev.present;
      echo_line_ok   <= ev.line_ok;
      echo_time      <= ev.echo_time;
      reads_total    <= read_cnt_next;
      timeouts_total <= timeout_cnt_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ultrasonic_echo_qualifier_top.sv -----
// Ultrasonic echo qualifier: takes one measurement word per cycle (stuck-high
// flag and echo time in us) and returns one result word per measurement with
// status, distance in 1/256 cm, presence flag and wrapping read and timeout
// counts. An accepted word sits in the input register while the scale
// multiply and limit compares feed the result register, which takes it once
// that register is empty or not stalled. Throughput is one word per cycle; a
// stalled result holds the pipeline only once the input register is also
// full. Limits and the absence threshold sit on an apb-style port and are
// meant to be written while no word is in flight.
`default_nettype none
module ultrasonic_echo_qualifier_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ueq_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [ueq_pkg::DATA_W-1:0]    pwdata,
  output logic      [ueq_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  input  wire logic                          meas_valid,
  output logic                               meas_stall,
  input  wire logic                          echo_stuck_high,
  input  wire logic [ueq_pkg::ECHO_W-1:0]    echo_duration,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic [2:0]                         status,
  output logic signed [ueq_pkg::DIST_W-1:0]  distance,
  output logic                               present,
  output logic                               echo_line_ok,
  output logic [ueq_pkg::ECHO_W-1:0]         echo_time,
  output logic [ueq_pkg::CNT_W-1:0]          reads_total,
  output logic [ueq_pkg::CNT_W-1:0]          timeouts_total
);

  ueq_pkg::cfg_t cfg;

  ueq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ueq_pipe u_pipe (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .meas_valid      (meas_valid),
    .meas_stall      (meas_stall),
    .echo_stuck_high (echo_stuck_high),
    .echo_duration   (echo_duration),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .status          (status),
    .distance        (distance),
    .present         (present),
    .echo_line_ok    (echo_line_ok),
    .echo_time       (echo_time),
    .reads_total     (reads_total),
    .timeouts_total  (timeouts_total)
  );

endmodule
`default_nettype wire

// ----- sv/ueq_checker.sv -----
// port-level checker for the echo qualifier and its bind
`default_nettype none
`include "assert_macros.svh"
module ueq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          res_valid,
  input wire logic                          res_stall,
  input wire logic [2:0]                    status,
  input wire logic signed [ueq_pkg::DIST_W-1:0] distance,
  input wire logic                          present,
  input wire logic                          echo_line_ok,
  input wire logic [ueq_pkg::ECHO_W-1:0]    echo_time,
  input wire logic [ueq_pkg::CNT_W-1:0]     reads_total
);

  `ASSERT_ALWAYS(a_no_result_after_reset, $past(rst) |-> !res_valid, "result word right after reset")
  `ASSERT_CLK(a_stall_holds, res_valid && res_stall |=> res_valid && $stable(status) && $stable(distance) && $stable(reads_total), "stalled result word changed")
  `ASSERT_CLK(a_sensor_error, res_valid && status == ueq_pkg::ST_SENSOR_ERROR |-> !present && !echo_line_ok && echo_time == '0 && distance == ueq_pkg::NO_DISTANCE, "sensor error word inconsistent")
  `ASSERT_CLK(a_timeout, res_valid && status == ueq_pkg::ST_TIMEOUT |-> echo_line_ok && echo_time == '0 && distance == ueq_pkg::NO_DISTANCE, "timeout word inconsistent")
  `ASSERT_CLK(a_ok, res_valid && status == ueq_pkg::ST_OK |-> present && echo_line_ok && echo_time != '0 && !distance[ueq_pkg::DIST_W-1], "ok word inconsistent")

endmodule

bind ultrasonic_echo_qualifier_top ueq_checker u_ueq_checker (.*);
`default_nettype wire

// ----- bench/ultrasonic_echo_qualifier_check.sv -----
// checker for the echo qualifier: watches both word channels and the apb port, predicts, compares
module ultrasonic_echo_qualifier_check
  import ueq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  input  logic                     meas_valid,
  input  logic                     meas_stall,
  input  logic                     echo_stuck_high,
  input  logic [ECHO_W-1:0]        echo_duration,
  input  logic                     res_valid,
  input  logic                     res_stall,
  input  logic [2:0]               status,
  input  logic signed [DIST_W-1:0] distance,
  input  logic                     present,
  input  logic                     echo_line_ok,
  input  logic [ECHO_W-1:0]        echo_time,
  input  logic [CNT_W-1:0]         reads_total,
  input  logic [CNT_W-1:0]         timeouts_total,
  output int                       pending,
  output int                       fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_US = 30000;
  localparam logic [29:0] CM_PER_US = 30'd17983;
  localparam int unsigned CM_FRAC = 12;
  localparam logic [DIST_W-1:0] DIST_CEIL = 18'd131071;
  localparam logic signed [DIST_W-1:0] NO_DIST = -18'sd256;

  typedef struct packed {
    status_t                  status;
    logic signed [DIST_W-1:0] distance;
    logic                     present;
    logic                     line_ok;
    logic [ECHO_W-1:0]        echo_time;
    logic [CNT_W-1:0]         reads;
    logic [CNT_W-1:0]         timeouts;
  } echo_result_t;

  cfg_t             limits;
  logic [THR_W-1:0] missed_run;
  logic [CNT_W-1:0] reads_seen;
  logic [CNT_W-1:0] timeouts_seen;
  echo_result_t     expected_q[$];
  echo_result_t     want;
  int               mismatches = 0;

  function automatic echo_result_t classify(input logic stuck, input logic [ECHO_W-1:0] dur_in);
    echo_result_t     r;
    logic [ECHO_W-1:0] dur;
    logic [29:0]       prod;
    logic [DIST_W-1:0] range_d;
    reads_seen = reads_seen + 1;
    r.status = ST_OK;
    r.distance = NO_DIST;
    r.present = 1'b1;
    r.line_ok = 1'b1;
    if (stuck) begin
      r.status = ST_SENSOR_ERROR;
      r.line_ok = 1'b0;
      r.present = 1'b0;
      r.echo_time = '0;
      missed_run = limits.absence_threshold;
    end else begin
      dur = (dur_in > LIMIT_US) ? '0 : dur_in;
      r.echo_time = dur;
      if (dur == 0) begin
        r.status = ST_TIMEOUT;
        timeouts_seen = timeouts_seen + 1;
        if (missed_run != 8'hff) missed_run = missed_run + 1;
        r.present = (missed_run < limits.absence_threshold);
      end else begin
        missed_run = '0;
        if (dur < limits.min_echo_time) begin
          r.status = ST_TOO_SHORT;
        end else if (dur > limits.max_echo_time) begin
          r.status = ST_TOO_LONG;
        end else begin
          prod = dur * CM_PER_US;
          range_d = prod >> CM_FRAC;
          r.status = (range_d < limits.min_distance || range_d > limits.max_distance) ?
                     ST_OUT_OF_RANGE : ST_OK;
          r.distance = (range_d > DIST_CEIL) ? DIST_CEIL : range_d;
        end
      end
    end
    r.reads = reads_seen;
    r.timeouts = timeouts_seen;
    return r;
  endfunction

  task automatic compare_word(input echo_result_t w);
    if (status !== w.status || distance !== w.distance || present !== w.present ||
        echo_line_ok !== w.line_ok || echo_time !== w.echo_time ||
        reads_total !== w.reads || timeouts_total !== w.timeouts) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t result word differs: expected st=%0d dist=%0d pres=%0b ok=%0b echo=%0d rd=%0d to=%0d, got st=%0d dist=%0d pres=%0b ok=%0b echo=%0d rd=%0d to=%0d",
                 $realtime, w.status, w.distance, w.present, w.line_ok, w.echo_time,
                 w.reads, w.timeouts, status, distance, present, echo_line_ok,
                 echo_time, reads_total, timeouts_total);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limits.min_echo_time = 15'd115;
      limits.max_echo_time = 15'd23500;
      limits.min_distance = 17'd512;
      limits.max_distance = 17'd102400;
      limits.absence_threshold = 8'd3;
      missed_run = '0;
      reads_seen = '0;
      timeouts_seen = '0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t result word with nothing expected: st=%0d dist=%0d", $realtime,
                     status, distance);
        end else begin
          want = expected_q.pop_front();
          compare_word(want);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_MIN_ECHO: limits.min_echo_time = pwdata[ECHO_W-1:0];
          REG_MAX_ECHO: limits.max_echo_time = pwdata[ECHO_W-1:0];
          REG_MIN_DIST: limits.min_distance = pwdata[DIST_CFG_W-1:0];
          REG_MAX_DIST: limits.max_distance = pwdata[DIST_CFG_W-1:0];
          REG_ABS_THR:  limits.absence_threshold = pwdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (meas_valid && !meas_stall)
        expected_q.push_back(classify(echo_stuck_high, echo_duration));
      pending <= expected_q.size();
    end
    fail_count <= mismatches;
  end

endmodule

// ----- bench/ultrasonic_echo_qualifier_top_test.sv -----
// testbench top for the echo qualifier: clock, reset, stimulus and verdict
module ultrasonic_echo_qualifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ueq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 180;
  localparam int CM_PER_US = 17983;
  localparam logic [2:0] REG_SPARE = 3'd5;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;
  logic                     meas_valid;
  logic                     meas_stall;
  logic                     echo_stuck_high;
  logic [ECHO_W-1:0]        echo_duration;
  logic                     res_valid;
  logic                     res_stall;
  logic [2:0]               status;
  logic signed [DIST_W-1:0] distance;
  logic                     present;
  logic                     echo_line_ok;
  logic [ECHO_W-1:0]        echo_time;
  logic [CNT_W-1:0]         reads_total;
  logic [CNT_W-1:0]         timeouts_total;

  int words_pending;
  int mismatch_total;
  int cycle_count = 0;
  bit steady = 1'b0;
  int cur_min_echo = 115;
  int cur_max_echo = 23500;
  int cur_min_dist = 512;
  int cur_max_dist = 102400;

  ultrasonic_echo_qualifier_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .meas_valid(meas_valid), .meas_stall(meas_stall),
    .echo_stuck_high(echo_stuck_high), .echo_duration(echo_duration),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .distance(distance), .present(present), .echo_line_ok(echo_line_ok),
    .echo_time(echo_time), .reads_total(reads_total), .timeouts_total(timeouts_total)
  );

  ultrasonic_echo_qualifier_check check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .meas_valid(meas_valid), .meas_stall(meas_stall),
    .echo_stuck_high(echo_stuck_high), .echo_duration(echo_duration),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .distance(distance), .present(present), .echo_line_ok(echo_line_ok),
    .echo_time(echo_time), .reads_total(reads_total), .timeouts_total(timeouts_total),
    .pending(words_pending), .fail_count(mismatch_total)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_measurement(input logic stuck, input logic [ECHO_W-1:0] dur);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      meas_valid <= 1'b0;
      @(posedge clk);
    end
    meas_valid <= 1'b1;
    echo_stuck_high <= stuck;
    echo_duration <= dur;
    @(posedge clk);
    while (meas_stall) @(posedge clk);
  endtask

  task automatic drain();
    meas_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_limits(input int min_e, input int max_e, input int min_d,
                              input int max_d, input int thr);
    drain();
    apb_write(REG_MIN_ECHO, min_e);
    apb_write(REG_MAX_ECHO, max_e);
    apb_write(REG_MIN_DIST, min_d);
    apb_write(REG_MAX_DIST, max_d);
    apb_write(REG_ABS_THR, thr);
    cur_min_echo = min_e;
    cur_max_echo = max_e;
    cur_min_dist = min_d;
    cur_max_dist = max_d;
  endtask

  function automatic logic [ECHO_W-1:0] pick_duration();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = int'($urandom_range(30001, 32767));
      2: v = cur_min_echo + int'($urandom_range(0, 4)) - 2;
      3: v = cur_max_echo + int'($urandom_range(0, 4)) - 2;
      4: v = (cur_min_dist * 4096) / CM_PER_US + int'($urandom_range(0, 4)) - 2;
      5: v = (cur_max_dist * 4096) / CM_PER_US + int'($urandom_range(0, 4)) - 2;
      6: v = int'($urandom_range(1, 300));
      default: v = int'($urandom_range(1, 30000));
    endcase
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return v[ECHO_W-1:0];
  endfunction

  // result side stall
  initial begin
    int hold;
    res_stall <= 1'b0;
    @(negedge rst);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 3);
      repeat (hold) begin
        res_stall <= 1'b1;
        @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
    end
  end

  initial begin
    int  sent;
    int  run;
    int  kind;
    int  min_e;
    int  min_d;
    bit  paused;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    meas_valid <= 1'b0;
    echo_stuck_high <= 1'b0;
    echo_duration <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at reset limits
    repeat (4) send_measurement(1'b0, 15'd0);
    send_measurement(1'b0, 15'd1000);
    send_measurement(1'b0, 15'd114);
    send_measurement(1'b0, 15'd115);
    send_measurement(1'b0, 15'd117);
    send_measurement(1'b0, 15'd23500);
    send_measurement(1'b0, 15'd23501);
    send_measurement(1'b0, 15'd30000);
    send_measurement(1'b0, 15'd30001);
    send_measurement(1'b0, 15'd32767);
    send_measurement(1'b1, 15'd32767);
    send_measurement(1'b1, 15'd0);
    send_measurement(1'b0, 15'd0);
    send_measurement(1'b0, 15'd5000);

    // widest limits, zero threshold, saturated distance
    write_limits(0, 30000, 0, 131071, 0);
    apb_write(REG_SPARE, 32'h0000_7fff);
    send_measurement(1'b0, 15'd30000);
    send_measurement(1'b0, 15'd1);
    send_measurement(1'b0, 15'd0);
    send_measurement(1'b0, 15'd0);
    send_measurement(1'b1, 15'd0);
    send_measurement(1'b0, 15'd0);

    for (int p = 0; p < 6; p++) begin
      steady = (p % 3 == 1);
      case (p)
        0: write_limits(115, 23500, 512, 102400, 3);
        1: begin
          write_limits(0, 30000, 0, 131071, 255);
          repeat (260) send_measurement(1'b0, 15'd0);
        end
        2: write_limits(30000, 0, 131071, 0, 1);
        default: begin
          min_e = $urandom_range(0, 3000);
          min_d = $urandom_range(0, 40000);
          write_limits(min_e, $urandom_range(min_e, 30000), min_d,
                       $urandom_range(min_d, 131071), $urandom_range(1, 255));
        end
      endcase
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_WORDS) begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          run = $urandom_range(2, 12);
          repeat (run) send_measurement(1'b0, 15'd0);
          sent += run;
        end else if (kind == 1) begin
          send_measurement(1'b1, $urandom_range(0, 32767));
          sent++;
        end else begin
          send_measurement(1'b0, pick_duration());
          sent++;
        end
        if (!paused && sent >= PHASE_WORDS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_total == 0 && words_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
